// ===== design/fcpa_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcpa_pkg
// shared constants, codes and types of the chunk pool allocator
// ---------------------------------------------------------------------------
package fcpa_pkg;

    localparam int DEF_MAX_CHUNKS = 1024;
    localparam int ADDR_W         = 32;
    localparam int SHIFT_W        = 5;
    localparam int COUNT_W        = 11;
    localparam int OUT_IDX_W      = 10;
    localparam int OUT_CNT_W      = 11;
    localparam int PADDR_W        = 4;
    localparam int PDATA_W        = 32;

    // request kinds
    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_FREE   = 2'd1;
    localparam logic [1:0] MODE_REINIT = 2'd2;
    localparam logic [1:0] MODE_NOP    = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_ALL_FREE = 2'd2;
    localparam logic [1:0] ST_BAD_ADDR = 2'd3;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_SHIFT = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    // reset values of the registers
    localparam logic [ADDR_W-1:0]  RST_BASE  = '0;
    localparam logic [SHIFT_W-1:0] RST_SHIFT = 5'd6;
    localparam logic [COUNT_W-1:0] RST_COUNT = 11'd1024;

    typedef struct packed {
        logic capture;   // take the input item, start the stack read
        logic commit;    // update pool state and load the result register
    } ctrl_cmd_t;

endpackage

// ===== design/fcpa_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcpa_ctrl
// sequencing of request capture, execute and result hand-off
// ---------------------------------------------------------------------------
module fcpa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output fcpa_pkg::ctrl_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold until the result register can take the new item
                if (slot_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        out_valid_next = cmd.commit ? 1'b1 : (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

// ===== design/fcpa_dpath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcpa_dpath
// free-list stack, pool counters, address decode and result register
// ---------------------------------------------------------------------------
module fcpa_dpath #(
    parameter int MAX_CHUNKS = fcpa_pkg::DEF_MAX_CHUNKS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fcpa_pkg::ctrl_cmd_t                 cmd,
    input  logic [1:0]                          in_mode,
    input  logic [fcpa_pkg::ADDR_W-1:0]         in_free_address,
    input  logic [fcpa_pkg::ADDR_W-1:0]         base_address,
    input  logic [fcpa_pkg::SHIFT_W-1:0]        chunk_shift,
    input  logic [fcpa_pkg::COUNT_W-1:0]        chunk_count,
    output logic [1:0]                          res_status,
    output logic [fcpa_pkg::ADDR_W-1:0]         res_chunk_address,
    output logic [fcpa_pkg::OUT_IDX_W-1:0]      res_chunk_index,
    output logic [fcpa_pkg::OUT_CNT_W-1:0]      res_used_chunks,
    output logic [fcpa_pkg::OUT_CNT_W-1:0]      res_peak_chunks
);

    localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int FRESH_RST = (MAX_CHUNKS < 1024) ? MAX_CHUNKS : 1024;
    localparam int AW = fcpa_pkg::ADDR_W;

    logic [IDX_W-1:0] stack_mem [MAX_CHUNKS];
    logic [IDX_W-1:0] rd_data_reg;

    logic [1:0]       mode_reg;
    logic [AW-1:0]    faddr_reg;

    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [CNT_W-1:0] fresh_reg, fresh_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] peak_reg, peak_next;

    logic [1:0]       status_reg, status_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [CNT_W-1:0] idx_out_reg, idx_out_next;

    logic [CNT_W-1:0] pool_n;
    logic [CNT_W-1:0] depth_dec, fresh_dec, used_inc;
    logic [IDX_W-1:0] rd_ptr, wr_ptr;
    logic [AW-1:0]    offset, low_mask, free_idx, alloc_off;
    logic [IDX_W-1:0] alloc_idx;
    logic             push;

    // effective pool size, limited by the stack depth
    always_comb begin
        if (32'(chunk_count) > 32'(MAX_CHUNKS)) begin
            pool_n = CNT_W'(MAX_CHUNKS);
        end else begin
            pool_n = CNT_W'(chunk_count);
        end
    end

    assign depth_dec = depth_reg - 1'b1;
    assign fresh_dec = fresh_reg - 1'b1;
    assign used_inc  = used_reg + 1'b1;
    assign rd_ptr    = depth_dec[IDX_W-1:0];
    assign wr_ptr    = depth_reg[IDX_W-1:0];

    // free decode
    assign offset   = faddr_reg - base_address;
    assign low_mask = (AW'(1) << chunk_shift) - AW'(1);
    assign free_idx = offset >> chunk_shift;

    // allocate: newest freed chunk first, else the highest fresh one
    assign alloc_idx = (depth_reg != '0) ? rd_data_reg : fresh_dec[IDX_W-1:0];
    assign alloc_off = AW'(alloc_idx) << chunk_shift;

    always_comb begin
        depth_next   = depth_reg;
        fresh_next   = fresh_reg;
        used_next    = used_reg;
        peak_next    = peak_reg;
        status_next  = fcpa_pkg::ST_OK;
        addr_next    = '0;
        idx_out_next = '0;
        push         = 1'b0;
        unique case (mode_reg)
            fcpa_pkg::MODE_ALLOC: begin
                if (depth_reg == '0 && fresh_reg == '0) begin
                    status_next = fcpa_pkg::ST_EMPTY;
                end else begin
                    if (depth_reg != '0) begin
                        depth_next = depth_dec;
                    end else begin
                        fresh_next = fresh_dec;
                    end
                    used_next = used_inc;
                    if (used_inc > peak_reg) begin
                        peak_next = used_inc;
                    end
                    addr_next    = base_address + alloc_off;
                    idx_out_next = CNT_W'(alloc_idx);
                end
            end
            fcpa_pkg::MODE_FREE: begin
                if ((offset & low_mask) != '0 || free_idx >= AW'(pool_n)) begin
                    status_next = fcpa_pkg::ST_BAD_ADDR;
                end else if (used_reg == '0 || depth_reg == CNT_W'(MAX_CHUNKS)) begin
                    status_next  = fcpa_pkg::ST_ALL_FREE;
                    idx_out_next = free_idx[CNT_W-1:0];
                end else begin
                    push         = 1'b1;
                    depth_next   = depth_reg + 1'b1;
                    used_next    = used_reg - 1'b1;
                    idx_out_next = free_idx[CNT_W-1:0];
                end
            end
            fcpa_pkg::MODE_REINIT: begin
                depth_next = '0;
                fresh_next = pool_n;
                used_next  = '0;
                peak_next  = '0;
            end
            fcpa_pkg::MODE_NOP: begin
            end
            default: begin
            end
        endcase
    end

    // stack memory, registered read
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rd_data_reg <= stack_mem[rd_ptr];
        end
        if (cmd.commit && push) begin
            stack_mem[wr_ptr] <= free_idx[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= in_mode;
            faddr_reg <= in_free_address;
        end
        if (cmd.commit) begin
            status_reg  <= status_next;
            addr_reg    <= addr_next;
            idx_out_reg <= idx_out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            fresh_reg <= CNT_W'(FRESH_RST);
            used_reg  <= '0;
            peak_reg  <= '0;
        end else if (cmd.commit) begin
            depth_reg <= depth_next;
            fresh_reg <= fresh_next;
            used_reg  <= used_next;
            peak_reg  <= peak_next;
        end
    end

    // counts follow the committed state
    logic [CNT_W-1:0] used_out_reg, peak_out_reg;
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            used_out_reg <= used_next;
            peak_out_reg <= peak_next;
        end
    end

    assign res_status        = status_reg;
    assign res_chunk_address = addr_reg;
    assign res_chunk_index   = fcpa_pkg::OUT_IDX_W'(idx_out_reg);
    assign res_used_chunks   = fcpa_pkg::OUT_CNT_W'(used_out_reg);
    assign res_peak_chunks   = fcpa_pkg::OUT_CNT_W'(peak_out_reg);

endmodule

// ===== design/fixed_chunk_pool_allocator_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fixed_chunk_pool_allocator_core
// fixed-size chunk pool allocator with a lifo free list
// ---------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  tuser: mode; tdata: free_address
//  m_        out  m_tvalid/m_tready  tuser: status; tdata: address, index, used, peak
//  apb       in   psel/penable       base_address, chunk_shift, chunk_count
//
//  each item is first captured, together with a read of the free-list stack
//  memory, whose read port is registered, and is then executed
//  the result sits in its own register, so a new item is taken while the
//  previous result still waits; the execute cycle holds while that register
//  is full and m_tready is low
//  aresetn is synchronous: counters cleared, pool full of fresh chunks
// ---------------------------------------------------------------------------
module fixed_chunk_pool_allocator_core #(
    parameter int MAX_CHUNKS = fcpa_pkg::DEF_MAX_CHUNKS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // [31:0] free_address
    input  logic [1:0]                     s_tuser,   // [1:0] mode
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [63:0]                    m_tdata,   // [31:0] chunk_address,
                                                      // [41:32] chunk_index,
                                                      // [52:42] used_chunks,
                                                      // [63:53] peak_chunks
    output logic [1:0]                     m_tuser,   // [1:0] status
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fcpa_pkg::PADDR_W-1:0]   paddr,
    input  logic [fcpa_pkg::PDATA_W-1:0]   pwdata,
    output logic [fcpa_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    logic [fcpa_pkg::ADDR_W-1:0]  base_reg;
    logic [fcpa_pkg::SHIFT_W-1:0] shift_reg;
    logic [fcpa_pkg::COUNT_W-1:0] count_reg;
    logic                         cfg_wr;
    logic [1:0]                   reg_sel;

    fcpa_pkg::ctrl_cmd_t cmd;

    logic [1:0]                      res_status;
    logic [fcpa_pkg::ADDR_W-1:0]     res_addr;
    logic [fcpa_pkg::OUT_IDX_W-1:0]  res_idx;
    logic [fcpa_pkg::OUT_CNT_W-1:0]  res_used;
    logic [fcpa_pkg::OUT_CNT_W-1:0]  res_peak;

    // register file: word index from the address, byte lane bits ignored
    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= fcpa_pkg::RST_BASE;
            shift_reg <= fcpa_pkg::RST_SHIFT;
            count_reg <= fcpa_pkg::RST_COUNT;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                fcpa_pkg::REG_BASE:  base_reg  <= pwdata;
                fcpa_pkg::REG_SHIFT: shift_reg <= pwdata[fcpa_pkg::SHIFT_W-1:0];
                fcpa_pkg::REG_COUNT: count_reg <= pwdata[fcpa_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            fcpa_pkg::REG_BASE:  prdata = base_reg;
            fcpa_pkg::REG_SHIFT: prdata = fcpa_pkg::PDATA_W'(shift_reg);
            fcpa_pkg::REG_COUNT: prdata = fcpa_pkg::PDATA_W'(count_reg);
            default:             prdata = '0;
        endcase
    end

    // sequencing
    fcpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // pool state and result
    fcpa_dpath #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .in_mode           (s_tuser),
        .in_free_address   (s_tdata),
        .base_address      (base_reg),
        .chunk_shift       (shift_reg),
        .chunk_count       (count_reg),
        .res_status        (res_status),
        .res_chunk_address (res_addr),
        .res_chunk_index   (res_idx),
        .res_used_chunks   (res_used),
        .res_peak_chunks   (res_peak)
    );

    assign m_tuser = res_status;
    assign m_tdata = {res_peak, res_used, res_idx, res_addr};

endmodule
